FILE: src/cfsnd_pkg.sv
// ----------------------------------------------------------------------------
// cfsnd_pkg
// Types, constants and register indexes for the credit flow control sender.
// ----------------------------------------------------------------------------
package cfsnd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_STATUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANT_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT_CODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_CH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd6;

  // reset values of the configuration registers
  localparam logic [7:0]  RST_CTRL_STATUS = 8'd176;
  localparam logic [7:0]  RST_BEGIN_CODE  = 8'd1;
  localparam logic [7:0]  RST_END_CODE    = 8'd2;
  localparam logic [7:0]  RST_GRANT_CODE  = 8'd3;
  localparam logic [7:0]  RST_ABORT_CODE  = 8'd4;
  localparam logic [7:0]  RST_SESSION_CH  = 8'd0;
  localparam logic [15:0] RST_TIMEOUT     = 16'd384;

  localparam logic [15:0] WAIT_COUNT_MAX  = 16'hffff;

  // host and partner command codes on cmd_i
  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_END   = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_PEER  = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;
  localparam logic [2:0] CMD_ABORT = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BEGIN,
    OP_END,
    OP_SEND,
    OP_PEER,
    OP_TICK,
    OP_ABORT
  } op_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_ACK,
    WAIT_CREDIT
  } wait_e;

  typedef struct packed {
    logic [7:0]  ctrl_status;
    logic [7:0]  begin_code;
    logic [7:0]  end_code;
    logic [7:0]  grant_code;
    logic [7:0]  abort_code;
    logic [7:0]  session_ch;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] second;
  } msg_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] chan;
    msg_t       msg;
    logic       send_exempt;  // host send is a control-status flow command
    logic       peer_grant;
    logic       peer_abort;
    logic [7:0] peer_data;
  } entry_t;

  // one result as it leaves the block
  typedef struct packed {
    logic tx_valid;
    msg_t tx;
    logic op_done;
    logic op_ok;
    logic failed_flag;
    logic busy_res;
  } result_t;

endpackage

FILE: src/cfsnd_front.sv
// ----------------------------------------------------------------------------
// cfsnd_front
// Decodes an incoming item into an operation and precomputes the code compares.
// ----------------------------------------------------------------------------
module cfsnd_front import cfsnd_pkg::*; (
  input  cfg_t       cfg_i,
  input  logic [2:0] cmd_i,
  input  logic [7:0] chan_i,
  input  logic [7:0] msg_status_i,
  input  logic [7:0] msg_first_i,
  input  logic [7:0] msg_second_i,
  input  logic [7:0] peer_command_i,
  input  logic [7:0] peer_data_i,
  output entry_t     entry_o
);

  logic flow_cmd;

  assign flow_cmd = (msg_first_i >= cfg_i.begin_code) && (msg_first_i <= cfg_i.abort_code);

  always_comb begin
    entry_o             = '0;
    entry_o.chan        = chan_i;
    entry_o.msg.status  = msg_status_i;
    entry_o.msg.first   = msg_first_i;
    entry_o.msg.second  = msg_second_i;
    entry_o.peer_data   = peer_data_i;
    entry_o.send_exempt = (msg_status_i == cfg_i.ctrl_status) && flow_cmd;
    // grant wins when grant and abort share a code
    entry_o.peer_grant  = (peer_command_i == cfg_i.grant_code);
    entry_o.peer_abort  = (peer_command_i != cfg_i.grant_code) &&
                          (peer_command_i == cfg_i.abort_code);
    case (cmd_i)
      CMD_BEGIN: entry_o.op = OP_BEGIN;
      CMD_END:   entry_o.op = OP_END;
      CMD_SEND:  entry_o.op = OP_SEND;
      CMD_PEER:  entry_o.op = OP_PEER;
      CMD_TICK:  entry_o.op = OP_TICK;
      CMD_ABORT: entry_o.op = OP_ABORT;
      default:   entry_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: src/cfsnd_fifo.sv
// ----------------------------------------------------------------------------
// cfsnd_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cfsnd_fifo import cfsnd_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output entry_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/cfsnd_back.sv
// ----------------------------------------------------------------------------
// cfsnd_back
// Executes queued items against the session and wait state, registers results.
// ----------------------------------------------------------------------------
module cfsnd_back import cfsnd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    entry_valid_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic        active_q, active_d;
  logic [7:0]  flow_chan_q, flow_chan_d;
  logic [3:0]  credits_q, credits_d;
  logic        ack_wait_q, ack_wait_d;
  logic [7:0]  ack_chan_q, ack_chan_d;
  logic        failed_q, failed_d;
  wait_e       wait_kind_q, wait_kind_d;
  logic        wait_is_end_q, wait_is_end_d;
  logic [15:0] wait_count_q, wait_count_d;
  msg_t        held_q, held_d;
  logic        out_valid_q;
  result_t     result_q, res_d;

  assign pop_o       = entry_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    logic        busy;
    logic [2:0]  g_ch;
    logic [3:0]  g_cr;
    logic [15:0] cnt;
    logic        good;

    active_d      = active_q;
    flow_chan_d   = flow_chan_q;
    credits_d     = credits_q;
    ack_wait_d    = ack_wait_q;
    ack_chan_d    = ack_chan_q;
    failed_d      = failed_q;
    wait_kind_d   = wait_kind_q;
    wait_is_end_d = wait_is_end_q;
    wait_count_d  = wait_count_q;
    held_d        = held_q;
    res_d         = '0;
    busy          = (wait_kind_q != WAIT_NONE);
    g_ch          = entry_i.peer_data[6:4];
    g_cr          = entry_i.peer_data[3:0];
    cnt           = (wait_count_q == WAIT_COUNT_MAX) ? wait_count_q : wait_count_q + 16'd1;
    good          = 1'b0;

    case (entry_i.op)
      OP_BEGIN, OP_END: begin
        if (!busy) begin
          if (entry_i.op == OP_BEGIN) begin
            active_d    = (entry_i.chan != cfg_i.session_ch);
            flow_chan_d = entry_i.chan;
            credits_d   = '0;
            failed_d    = 1'b0;
          end
          ack_chan_d      = entry_i.chan;
          ack_wait_d      = 1'b1;
          res_d.tx_valid  = 1'b1;
          res_d.tx.status = cfg_i.ctrl_status;
          res_d.tx.first  = (entry_i.op == OP_BEGIN) ? cfg_i.begin_code : cfg_i.end_code;
          res_d.tx.second = entry_i.chan;
          wait_kind_d     = WAIT_ACK;
          wait_is_end_d   = (entry_i.op == OP_END);
          wait_count_d    = '0;
        end
      end
      OP_SEND: begin
        if (!busy) begin
          if (!active_q || entry_i.send_exempt) begin
            res_d.tx_valid = 1'b1;
            res_d.tx       = entry_i.msg;
            res_d.op_done  = 1'b1;
            res_d.op_ok    = 1'b1;
          end else if (credits_q != '0) begin
            res_d.op_done = 1'b1;
            if (!failed_q) begin
              res_d.tx_valid = 1'b1;
              res_d.tx       = entry_i.msg;
              res_d.op_ok    = 1'b1;
              credits_d      = credits_q - 4'd1;
            end
          end else begin
            held_d       = entry_i.msg;
            wait_kind_d  = WAIT_CREDIT;
            wait_count_d = '0;
          end
        end
      end
      OP_PEER: begin
        if (entry_i.peer_grant) begin
          if (g_cr != '0) begin
            if (ack_wait_q && ({5'd0, g_ch} == ack_chan_q)) begin
              ack_wait_d = 1'b0;
            end
            if (active_q && ({5'd0, g_ch} == flow_chan_q)) begin
              credits_d = g_cr;
              failed_d  = 1'b0;
            end
          end
        end else if (entry_i.peer_abort) begin
          active_d  = 1'b0;
          credits_d = '0;
          failed_d  = 1'b1;
          if (entry_i.peer_data == ack_chan_q) begin
            ack_wait_d = 1'b0;
          end
        end
        // resolve a pending wait against the updated state
        if (wait_kind_q == WAIT_ACK && !ack_wait_d) begin
          good = !failed_d;
          if (wait_is_end_q) begin
            if (ack_chan_q == flow_chan_q) begin
              active_d  = 1'b0;
              credits_d = '0;
            end
          end else if (good && (ack_chan_q != cfg_i.session_ch)) begin
            active_d = 1'b1;
          end
          wait_kind_d   = WAIT_NONE;
          res_d.op_done = 1'b1;
          res_d.op_ok   = good;
        end else if (wait_kind_q == WAIT_CREDIT && !(active_d && credits_d == '0)) begin
          wait_kind_d   = WAIT_NONE;
          res_d.op_done = 1'b1;
          if (!failed_d) begin
            res_d.tx_valid = 1'b1;
            res_d.tx       = held_q;
            res_d.op_ok    = 1'b1;
            if (credits_d != '0) begin
              credits_d = credits_d - 4'd1;
            end
          end
        end
      end
      OP_TICK: begin
        if (busy) begin
          wait_count_d = cnt;
          if (cnt > cfg_i.timeout) begin
            res_d.tx_valid  = 1'b1;
            res_d.tx.status = cfg_i.ctrl_status;
            res_d.tx.first  = cfg_i.abort_code;
            res_d.tx.second = (wait_kind_q == WAIT_ACK) ? ack_chan_q : flow_chan_q;
            if (wait_kind_q == WAIT_ACK) begin
              ack_wait_d = 1'b0;
            end
            active_d      = 1'b0;
            credits_d     = '0;
            failed_d      = 1'b1;
            wait_kind_d   = WAIT_NONE;
            res_d.op_done = 1'b1;
          end
        end
      end
      OP_ABORT: begin
        if (!busy) begin
          res_d.tx_valid  = 1'b1;
          res_d.tx.status = cfg_i.ctrl_status;
          res_d.tx.first  = cfg_i.abort_code;
          res_d.tx.second = cfg_i.session_ch;
          ack_wait_d      = 1'b0;
          active_d        = 1'b0;
          credits_d       = '0;
          failed_d        = 1'b1;
        end
      end
      default: ;
    endcase

    res_d.failed_flag = failed_d;
    res_d.busy_res    = (wait_kind_d != WAIT_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      flow_chan_q   <= '0;
      credits_q     <= '0;
      ack_wait_q    <= 1'b0;
      ack_chan_q    <= '0;
      failed_q      <= 1'b0;
      wait_kind_q   <= WAIT_NONE;
      wait_is_end_q <= 1'b0;
      wait_count_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q      <= active_d;
        flow_chan_q   <= flow_chan_d;
        credits_q     <= credits_d;
        ack_wait_q    <= ack_wait_d;
        ack_chan_q    <= ack_chan_d;
        failed_q      <= failed_d;
        wait_kind_q   <= wait_kind_d;
        wait_is_end_q <= wait_is_end_d;
        wait_count_q  <= wait_count_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      held_q   <= held_d;
      result_q <= res_d;
    end
  end

  // a credit wait only lasts while the flow is active with no credit left
  a_credit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_kind_q == WAIT_CREDIT) |-> (active_q && credits_q == '0))
    else $error("credit wait with credits or inactive flow");

  // an acknowledge wait always has its grant outstanding
  a_ack_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_kind_q == WAIT_ACK) |-> ack_wait_q)
    else $error("acknowledge wait without pending grant");

  // a taken result with nothing behind it empties the output register
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !entry_valid_i) |=> !out_valid_q)
    else $error("result held after it was taken");

endmodule

FILE: src/credit_flow_control_sender_core.sv
// ----------------------------------------------------------------------------
// credit_flow_control_sender_core
// Send side of a credit-based flow control link.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result, in order. The block sustains
// one item per clock while the output is not stalled: the front decodes an item
// in the cycle it is accepted and writes it into a short queue, and the back
// pops one queued item per cycle unless the output stalls, updates the session
// state and loads the output register. Each result passes through the queue
// and then the output register before it is presented on the output.
// Output stalls hold the result register and fill the two-entry queue, and
// only a full queue stalls the input. Waits for a grant or a credit are held
// states, not stalls: while busy, host begin, end, send and abort items are
// ignored and give an empty result. Configuration registers may only be
// written while no item is in flight.
module credit_flow_control_sender_core import cfsnd_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            cmd_i,
  input  logic [7:0]            chan_i,
  input  logic [7:0]            msg_status_i,
  input  logic [7:0]            msg_first_i,
  input  logic [7:0]            msg_second_i,
  input  logic [7:0]            peer_command_i,
  input  logic [7:0]            peer_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  tx_valid_o,
  output logic [7:0]            tx_status_o,
  output logic [7:0]            tx_first_o,
  output logic [7:0]            tx_second_o,
  output logic                  op_done_o,
  output logic                  op_ok_o,
  output logic                  failed_flag_o,
  output logic                  busy_res_o,
  output logic                  last_o
);

  cfg_t    cfg_q;
  entry_t  front_entry, queue_entry;
  logic    queue_full, queue_valid, queue_pop;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctrl_status <= RST_CTRL_STATUS;
      cfg_q.begin_code  <= RST_BEGIN_CODE;
      cfg_q.end_code    <= RST_END_CODE;
      cfg_q.grant_code  <= RST_GRANT_CODE;
      cfg_q.abort_code  <= RST_ABORT_CODE;
      cfg_q.session_ch  <= RST_SESSION_CH;
      cfg_q.timeout     <= RST_TIMEOUT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CTRL_STATUS: cfg_q.ctrl_status <= cfg_data_i[7:0];
        CFG_BEGIN_CODE:  cfg_q.begin_code  <= cfg_data_i[7:0];
        CFG_END_CODE:    cfg_q.end_code    <= cfg_data_i[7:0];
        CFG_GRANT_CODE:  cfg_q.grant_code  <= cfg_data_i[7:0];
        CFG_ABORT_CODE:  cfg_q.abort_code  <= cfg_data_i[7:0];
        CFG_SESSION_CH:  cfg_q.session_ch  <= cfg_data_i[7:0];
        CFG_TIMEOUT:     cfg_q.timeout     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfsnd_front u_front (
    .cfg_i          (cfg_q),
    .cmd_i          (cmd_i),
    .chan_i         (chan_i),
    .msg_status_i   (msg_status_i),
    .msg_first_i    (msg_first_i),
    .msg_second_i   (msg_second_i),
    .peer_command_i (peer_command_i),
    .peer_data_i    (peer_data_i),
    .entry_o        (front_entry)
  );

  assign in_stall_o = queue_full;

  cfsnd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (front_entry),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .data_o  (queue_entry)
  );

  cfsnd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_valid_i (queue_valid),
    .entry_i       (queue_entry),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_o      (result)
  );

  assign tx_valid_o    = result.tx_valid;
  assign tx_status_o   = result.tx.status;
  assign tx_first_o    = result.tx.first;
  assign tx_second_o   = result.tx.second;
  assign op_done_o     = result.op_done;
  assign op_ok_o       = result.op_ok;
  assign failed_flag_o = result.failed_flag;
  assign busy_res_o    = result.busy_res;
  assign last_o        = 1'b1;

endmodule

FILE: verif/flow_link_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_link_checker
// Watches the config, item and result channels of the credit flow control
// sender, keeps its own copy of the session state, predicts one result per
// accepted item and compares every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module flow_link_checker import cfsnd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [2:0]            cmd_i,
  input  logic [7:0]            chan_i,
  input  logic [7:0]            msg_status_i,
  input  logic [7:0]            msg_first_i,
  input  logic [7:0]            msg_second_i,
  input  logic [7:0]            peer_command_i,
  input  logic [7:0]            peer_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  tx_valid_i,
  input  logic [7:0]            tx_status_i,
  input  logic [7:0]            tx_first_i,
  input  logic [7:0]            tx_second_i,
  input  logic                  op_done_i,
  input  logic                  op_ok_i,
  input  logic                  failed_flag_i,
  input  logic                  busy_res_i,
  input  logic                  last_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  cfg_t        link_cfg;
  logic        active, ack_wait, failed, wait_is_end;
  logic [7:0]  flow_chan, ack_chan;
  logic [3:0]  credits;
  wait_e       wait_state;
  logic [15:0] wait_count;
  msg_t        held_msg;

  result_t     next_res;
  result_t     tx_results_due[$];
  int unsigned mismatch_count;

  function automatic void reset_link_state();
    link_cfg    = '{ctrl_status: RST_CTRL_STATUS, begin_code: RST_BEGIN_CODE,
                    end_code: RST_END_CODE, grant_code: RST_GRANT_CODE,
                    abort_code: RST_ABORT_CODE, session_ch: RST_SESSION_CH,
                    timeout: RST_TIMEOUT};
    active      = 1'b0;
    ack_wait    = 1'b0;
    failed      = 1'b0;
    wait_is_end = 1'b0;
    flow_chan   = '0;
    ack_chan    = '0;
    credits     = '0;
    wait_state  = WAIT_NONE;
    wait_count  = '0;
    held_msg    = '0;
  endfunction

  function automatic void emit(logic [7:0] s, logic [7:0] f, logic [7:0] d);
    next_res.tx_valid = 1'b1;
    next_res.tx       = '{status: s, first: f, second: d};
  endfunction

  function automatic void complete(logic success);
    next_res.op_done = 1'b1;
    next_res.op_ok   = success;
  endfunction

  function automatic void start_ack(logic [7:0] code, logic [7:0] ch, logic is_end);
    ack_chan    = ch;
    ack_wait    = 1'b1;
    emit(link_cfg.ctrl_status, code, ch);
    wait_state  = WAIT_ACK;
    wait_is_end = is_end;
    wait_count  = '0;
  endfunction

  function automatic void partner_msg(logic [7:0] pc, logic [7:0] pd);
    logic [7:0] ch;
    logic [3:0] cr;
    ch = {5'b0, pd[6:4]};
    cr = pd[3:0];
    // grant wins when grant and abort share a code
    if (pc == link_cfg.grant_code) begin
      if (cr == '0) return;
      if (ack_wait && ch == ack_chan) ack_wait = 1'b0;
      if (active && ch == flow_chan) begin
        credits = cr;
        failed  = 1'b0;
      end
    end else if (pc == link_cfg.abort_code) begin
      active  = 1'b0;
      credits = '0;
      failed  = 1'b1;
      if (pd == ack_chan) ack_wait = 1'b0;
    end
  endfunction

  function automatic void resolve_wait();
    logic good;
    if (wait_state == WAIT_ACK && !ack_wait) begin
      good = !failed;
      if (wait_is_end) begin
        if (ack_chan == flow_chan) begin
          active  = 1'b0;
          credits = '0;
        end
      end else if (good && ack_chan != link_cfg.session_ch) begin
        active = 1'b1;
      end
      wait_state = WAIT_NONE;
      complete(good);
    end else if (wait_state == WAIT_CREDIT && !(active && credits == '0)) begin
      wait_state = WAIT_NONE;
      if (failed) begin
        complete(1'b0);
      end else begin
        emit(held_msg.status, held_msg.first, held_msg.second);
        if (credits != '0) credits--;
        complete(1'b1);
      end
    end
  endfunction

  function automatic void count_tick();
    if (wait_state == WAIT_NONE) return;
    if (wait_count != WAIT_COUNT_MAX) wait_count++;
    if (wait_count <= link_cfg.timeout) return;
    if (wait_state == WAIT_ACK) begin
      emit(link_cfg.ctrl_status, link_cfg.abort_code, ack_chan);
      ack_wait = 1'b0;
    end else begin
      emit(link_cfg.ctrl_status, link_cfg.abort_code, flow_chan);
    end
    active     = 1'b0;
    credits    = '0;
    failed     = 1'b1;
    wait_state = WAIT_NONE;
    complete(1'b0);
  endfunction

  function automatic void host_send(logic [7:0] s, logic [7:0] f, logic [7:0] d);
    logic flow_cmd, uses_credit;
    flow_cmd    = (f >= link_cfg.begin_code) && (f <= link_cfg.abort_code);
    uses_credit = active && !(s == link_cfg.ctrl_status && flow_cmd);
    if (!uses_credit) begin
      emit(s, f, d);
      complete(1'b1);
    end else if (credits != '0) begin
      if (failed) begin
        complete(1'b0);
      end else begin
        emit(s, f, d);
        credits--;
        complete(1'b1);
      end
    end else begin
      held_msg   = '{status: s, first: f, second: d};
      wait_state = WAIT_CREDIT;
      wait_count = '0;
    end
  endfunction

  function automatic void advance_link();
    logic busy;
    busy     = (wait_state != WAIT_NONE);
    next_res = '0;
    case (cmd_i)
      CMD_BEGIN: begin
        if (!busy) begin
          active    = (chan_i != link_cfg.session_ch);
          flow_chan = chan_i;
          credits   = '0;
          failed    = 1'b0;
          start_ack(link_cfg.begin_code, chan_i, 1'b0);
        end
      end
      CMD_END: begin
        if (!busy) start_ack(link_cfg.end_code, chan_i, 1'b1);
      end
      CMD_SEND: begin
        if (!busy) host_send(msg_status_i, msg_first_i, msg_second_i);
      end
      CMD_PEER: begin
        partner_msg(peer_command_i, peer_data_i);
        resolve_wait();
      end
      CMD_TICK: count_tick();
      CMD_ABORT: begin
        if (!busy) begin
          emit(link_cfg.ctrl_status, link_cfg.abort_code, link_cfg.session_ch);
          ack_wait = 1'b0;
          active   = 1'b0;
          credits  = '0;
          failed   = 1'b1;
        end
      end
      default: ;
    endcase
    next_res.failed_flag = failed;
    next_res.busy_res    = (wait_state != WAIT_NONE);
  endfunction

  function automatic void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CTRL_STATUS: link_cfg.ctrl_status = data[7:0];
      CFG_BEGIN_CODE:  link_cfg.begin_code  = data[7:0];
      CFG_END_CODE:    link_cfg.end_code    = data[7:0];
      CFG_GRANT_CODE:  link_cfg.grant_code  = data[7:0];
      CFG_ABORT_CODE:  link_cfg.abort_code  = data[7:0];
      CFG_SESSION_CH:  link_cfg.session_ch  = data[7:0];
      CFG_TIMEOUT:     link_cfg.timeout     = data;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      reset_link_state();
      tx_results_due.delete();
      mismatch_count = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_cfg(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (tx_results_due.size() == 0) begin
          $display("%0t: result with no item outstanding: expected none, actual tx %b %h",
                   $time, tx_valid_i, {tx_status_i, tx_first_i, tx_second_i});
          mismatch_count++;
        end else begin
          due = tx_results_due.pop_front();
          check_field("tx_valid", due.tx_valid, tx_valid_i);
          check_field("tx_status", due.tx.status, tx_status_i);
          check_field("tx_first", due.tx.first, tx_first_i);
          check_field("tx_second", due.tx.second, tx_second_i);
          check_field("op_done", due.op_done, op_done_i);
          check_field("op_ok", due.op_ok, op_ok_i);
          check_field("failed_flag", due.failed_flag, failed_flag_i);
          check_field("busy_res", due.busy_res, busy_res_i);
          check_field("last", 1'b1, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_link();
        tx_results_due.push_back(next_res);
      end
      fail_count_o <= mismatch_count;
      pending_o    <= tx_results_due.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the credit flow control sender: a directed opening, then
// random sessions of begin, end, send, grant, abort and tick items under
// several register settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import cfsnd_pkg::*;

  localparam int unsigned          LIMIT_CYCLES   = 300000;
  localparam int unsigned          PHASES         = 9;
  localparam int unsigned          PHASE_ITEMS    = 150;
  localparam int unsigned          QUIET_PHASE    = 3;
  localparam logic [2:0]           CMD_SPARE_A    = 3'd6;
  localparam logic [2:0]           CMD_SPARE_B    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [2:0]            cmd          = '0;
  logic [7:0]            chan         = '0;
  logic [7:0]            msg_status   = '0;
  logic [7:0]            msg_first    = '0;
  logic [7:0]            msg_second   = '0;
  logic [7:0]            peer_command = '0;
  logic [7:0]            peer_data    = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  tx_valid;
  logic [7:0]            tx_status, tx_first, tx_second;
  logic                  op_done, op_ok, failed_flag, busy_res, last;
  int unsigned           fail_count, pending;

  int unsigned           idle_pct = 28;
  cfg_t                  link_cfg;
  logic [7:0]            recent_chan = 8'd2;

  credit_flow_control_sender_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .chan_i         (chan),
    .msg_status_i   (msg_status),
    .msg_first_i    (msg_first),
    .msg_second_i   (msg_second),
    .peer_command_i (peer_command),
    .peer_data_i    (peer_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tx_valid_o     (tx_valid),
    .tx_status_o    (tx_status),
    .tx_first_o     (tx_first),
    .tx_second_o    (tx_second),
    .op_done_o      (op_done),
    .op_ok_o        (op_ok),
    .failed_flag_o  (failed_flag),
    .busy_res_o     (busy_res),
    .last_o         (last)
  );

  flow_link_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_i          (cmd),
    .chan_i         (chan),
    .msg_status_i   (msg_status),
    .msg_first_i    (msg_first),
    .msg_second_i   (msg_second),
    .peer_command_i (peer_command),
    .peer_data_i    (peer_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tx_valid_i     (tx_valid),
    .tx_status_i    (tx_status),
    .tx_first_i     (tx_first),
    .tx_second_i    (tx_second),
    .op_done_i      (op_done),
    .op_ok_i        (op_ok),
    .failed_flag_i  (failed_flag),
    .busy_res_i     (busy_res),
    .last_i         (last),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("credit_flow_control_sender_core regression: fail");
    $finish;
  end

  task automatic send_item(input logic [2:0] c, input logic [7:0] ch, input logic [7:0] s,
                           input logic [7:0] f, input logic [7:0] d, input logic [7:0] pc,
                           input logic [7:0] pd);
    in_valid     <= 1'b1;
    cmd          <= c;
    chan         <= ch;
    msg_status   <= s;
    msg_first    <= f;
    msg_second   <= d;
    peer_command <= pc;
    peer_data    <= pd;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until every result has come back, then let the pipeline settle
  task automatic drain_link();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic choose_link_cfg(input int unsigned phase);
    logic [7:0] base;
    base = 8'($urandom_range(0, 100));
    link_cfg = '{ctrl_status: 8'($urandom), begin_code: base, end_code: base + 8'd1,
                 grant_code: base + 8'd2, abort_code: base + 8'($urandom_range(3, 150)),
                 session_ch: 8'($urandom_range(0, 7)),
                 timeout: 16'($urandom_range(1, 20))};
    case (phase)
      0: link_cfg = '{ctrl_status: RST_CTRL_STATUS, begin_code: RST_BEGIN_CODE,
                      end_code: RST_END_CODE, grant_code: RST_GRANT_CODE,
                      abort_code: RST_ABORT_CODE, session_ch: RST_SESSION_CH,
                      timeout: 16'd3};
      1: link_cfg = '{ctrl_status: 8'd255, begin_code: 8'd0, end_code: 8'd255,
                      grant_code: 8'd128, abort_code: 8'd255, session_ch: 8'd7,
                      timeout: 16'd1};
      // grant and abort on one code, zero timeout
      2: link_cfg = '{ctrl_status: 8'd0, begin_code: 8'd10, end_code: 8'd11,
                      grant_code: 8'd12, abort_code: 8'd12, session_ch: 8'd255,
                      timeout: 16'd0};
      QUIET_PHASE: link_cfg = '{ctrl_status: RST_CTRL_STATUS, begin_code: RST_BEGIN_CODE,
                      end_code: RST_END_CODE, grant_code: RST_GRANT_CODE,
                      abort_code: RST_ABORT_CODE, session_ch: RST_SESSION_CH,
                      timeout: 16'hffff};
      // empty flow command range
      5: link_cfg = '{ctrl_status: 8'($urandom), begin_code: 8'd200, end_code: 8'd8,
                      grant_code: 8'd7, abort_code: 8'd5, session_ch: 8'd3,
                      timeout: 16'd2};
      default: ;
    endcase
  endtask

  task automatic program_link_cfg();
    write_reg(CFG_CTRL_STATUS, {8'($urandom), link_cfg.ctrl_status});
    write_reg(CFG_BEGIN_CODE,  {8'($urandom), link_cfg.begin_code});
    write_reg(CFG_END_CODE,    {8'($urandom), link_cfg.end_code});
    write_reg(CFG_GRANT_CODE,  {8'($urandom), link_cfg.grant_code});
    write_reg(CFG_ABORT_CODE,  {8'($urandom), link_cfg.abort_code});
    write_reg(CFG_SESSION_CH,  {8'($urandom), link_cfg.session_ch});
    write_reg(CFG_TIMEOUT,     link_cfg.timeout);
    write_reg(CFG_UNUSED_IDX,  16'($urandom));
  endtask

  // mostly small channels so grants hit the open flow; random fill elsewhere
  task automatic random_link_item();
    int unsigned pick;
    logic [2:0]  c;
    logic [7:0]  ch, s, f, d, pc, pd;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1:    ch = 8'($urandom);
      2:       ch = link_cfg.session_ch;
      default: ch = 8'($urandom_range(0, 7));
    endcase
    s  = 8'($urandom);
    f  = 8'($urandom);
    d  = 8'($urandom);
    pc = 8'($urandom);
    pd = 8'($urandom);
    if (pick < 12) begin
      c = CMD_BEGIN;
      recent_chan = ch;
    end else if (pick < 20) begin
      c = CMD_END;
      if ($urandom_range(0, 2) != 0) ch = recent_chan;
    end else if (pick < 44) begin
      c = CMD_SEND;
      if ($urandom_range(0, 4) == 0) begin
        s = link_cfg.ctrl_status;
        f = 8'($urandom_range(link_cfg.begin_code, link_cfg.abort_code));
      end
    end else if (pick < 64) begin
      c  = CMD_PEER;
      pc = link_cfg.grant_code;
      if ($urandom_range(0, 9) < 7) pd[6:4] = recent_chan[2:0];
      pd[3:0] = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    end else if (pick < 69) begin
      c  = CMD_PEER;
      pc = link_cfg.abort_code;
      if ($urandom_range(0, 1) == 0) pd = recent_chan;
    end else if (pick < 72) begin
      c = CMD_PEER;
    end else if (pick < 94) begin
      c = CMD_TICK;
    end else if (pick < 98) begin
      c = CMD_ABORT;
    end else begin
      c = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
    end
    send_item(c, ch, s, f, d, pc, pd);
  endtask

  // runs with reset register values
  task automatic run_directed();
    send_item(CMD_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // idle tick
    send_item(CMD_SPARE_A, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(CMD_SPARE_B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_SEND,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_SEND,    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(CMD_BEGIN,   8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // host items while waiting for the grant are dropped
    send_item(CMD_BEGIN,   8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_SEND,    8'h00, 8'h90, 8'h11, 8'h22, 8'h00, 8'h00);
    send_item(CMD_ABORT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_END,     8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_GRANT_CODE, 8'h20);  // no credits
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_GRANT_CODE, 8'h21);
    send_item(CMD_SEND,    8'h00, 8'h90, 8'h3c, 8'h7f, 8'h00, 8'h00);
    send_item(CMD_SEND,    8'h00, 8'h91, 8'h40, 8'h01, 8'h00, 8'h00);  // held
    send_item(CMD_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_GRANT_CODE, 8'h2f);
    send_item(CMD_SEND,    8'h00, RST_CTRL_STATUS, RST_ABORT_CODE, 8'h55, 8'h00, 8'h00);
    send_item(CMD_SEND,    8'h00, RST_CTRL_STATUS, RST_ABORT_CODE + 8'd1, 8'haa, 8'h00, 8'h00);
    send_item(CMD_END,     8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_GRANT_CODE, 8'ha1);
    send_item(CMD_ABORT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_BEGIN,   RST_SESSION_CH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_ABORT_CODE, RST_SESSION_CH);
    // partner abort compares all eight data bits with the channel
    send_item(CMD_BEGIN,   8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_ABORT_CODE, 8'h83);
    send_item(CMD_PEER,    8'h00, 8'h00, 8'h00, 8'h00, RST_GRANT_CODE, 8'h31);
  endtask

  initial begin
    int unsigned phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (phase = 0; phase < PHASES; phase++) begin
      drain_link();
      choose_link_cfg(phase);
      program_link_cfg();
      idle_pct = (phase == QUIET_PHASE) ? 0 : 28;
      @(posedge clk);
      repeat (PHASE_ITEMS) random_link_item();
    end
    idle_pct = 28;
    drain_link();
    if (fail_count == 0) begin
      $display("credit_flow_control_sender_core regression: pass");
    end else begin
      $display("credit_flow_control_sender_core regression: fail");
    end
    $finish;
  end

endmodule
